FILE: rtl/srec_pkg.sv
// ----------------------------------------------------------------------------
// srec_pkg
// shared types, constants and helpers for the s-record line checker
// ----------------------------------------------------------------------------
package srec_pkg;

  localparam int unsigned POS_W = 10;
  localparam int unsigned LEN_W = POS_W + 1;
  localparam logic [POS_W-1:0] POSITION_LIMIT = '1;
  localparam int unsigned MAX_LINE_CHARS_DEFAULT = 514;

  // power of two so the pointers wrap on their own
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_S    = 8'h53;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_F    = 8'h46;
  localparam logic [7:0] HEX_A_VALUE = 8'd10;

  localparam logic [4:0] DEC_DIGIT_MAX = 5'd9;
  localparam logic [4:0] RESERVED_TYPE = 5'd4;
  localparam logic [7:0] SUM_GOOD      = 8'hFF;
  localparam logic [LEN_W-1:0] HEADER_CHARS = LEN_W'(4);
  localparam logic [LEN_W-1:0] FRAME_CHARS  = LEN_W'(6);

  typedef enum logic [3:0] {
    REC_S0 = 4'd0, REC_S1 = 4'd1, REC_S2 = 4'd2, REC_S3 = 4'd3,
    REC_S4 = 4'd4, REC_S5 = 4'd5, REC_S6 = 4'd6, REC_S7 = 4'd7,
    REC_S8 = 4'd8, REC_S9 = 4'd9, REC_SA = 4'd10, REC_SB = 4'd11,
    REC_SC = 4'd12, REC_SD = 4'd13, REC_SE = 4'd14, REC_SF = 4'd15
  } rec_type_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_FORMAT   = 3'd1,
    ERR_LENGTH   = 3'd2,
    ERR_CHECKSUM = 3'd3,
    ERR_COUNT    = 3'd4
  } err_kind_t;

  // per-line summary handed from the scanner to the verdict stage
  typedef struct packed {
    logic             format_ok;
    logic [LEN_W-1:0] line_len;
    rec_type_t        record_type;
    logic [7:0]       decl_count;
    logic [7:0]       byte_sum;
    logic [31:0]      field_value;
  } line_sum_t;

  typedef struct packed {
    logic              full;
    logic              avail;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  // bit 4 set when the character is not an uppercase hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = c - CHAR_A + HEX_A_VALUE;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      return {1'b0, c[3:0]};
    end else if (c >= CHAR_A && c <= CHAR_F) begin
      return {1'b0, d[3:0]};
    end else begin
      return 5'h10;
    end
  endfunction

  function automatic logic [3:0] addr_chars(input rec_type_t t);
    unique case (t)
      REC_S2, REC_S6, REC_S8: return 4'd6;
      REC_S3, REC_S7:         return 4'd8;
      default:                return 4'd4;
    endcase
  endfunction

endpackage

FILE: rtl/srec_line_checker_core.sv
// ----------------------------------------------------------------------------
// srec_line_checker_core
// checks streamed s-record lines one character per transfer and gives one
// verdict transfer per line
//
//   channel | dir | fields
//   s_*     | in  | tdata[7:0] line_char, tlast end_of_line
//   m_*     | out | tdata[0] line_valid, [3:1] error_kind,
//           |     |   [35:4] data_records_seen, [39:36] zero
//
// one character per cycle while s_tready is high; the scanner updates its line
// state in the cycle of the transfer. a verdict passes from the summary queue
// through the verdict register. s_tready drops only while the two-entry
// summary queue is full, which needs the output stalled; no clearing pass
// after rst
// ----------------------------------------------------------------------------
module srec_line_checker_core #(
  parameter int unsigned MAX_LINE_CHARS = srec_pkg::MAX_LINE_CHARS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // line_char
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // line_valid, error_kind, data_records_seen, pad
);

  srec_pkg::line_sum_t push_data, pop_data;
  srec_pkg::q_stat_t   q_stat;
  srec_pkg::err_kind_t error_kind;
  logic                push, pop;
  logic                line_valid;
  logic [31:0]         data_records_seen;

  assign s_tready = !q_stat.full;
  assign m_tdata  = {4'b0, data_records_seen, error_kind, line_valid};

  srec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_char   (s_tdata),
    .in_last   (s_tlast),
    .push      (push),
    .push_data (push_data)
  );

  srec_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  srec_back #(
    .MAX_LINE_CHARS (MAX_LINE_CHARS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_avail           (q_stat.avail),
    .q_data            (pop_data),
    .pop               (pop),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .line_valid        (line_valid),
    .error_kind        (error_kind),
    .data_records_seen (data_records_seen)
  );

  a_valid_iff_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (line_valid == (error_kind == srec_pkg::ERR_NONE)))
    else $error("line_valid disagrees with error_kind");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (error_kind <= srec_pkg::ERR_COUNT))
    else $error("error_kind out of range");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push |=> (q_stat.count != '0))
    else $error("line summary lost in queue");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("push into full queue");

endmodule

FILE: rtl/srec_front.sv
// ----------------------------------------------------------------------------
// srec_front
// character scanner: decodes hex digits, tracks position, byte sum and the
// count field, and pushes one line summary at the end of each line
// ----------------------------------------------------------------------------
module srec_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_char,
  input  logic                  in_last,
  output logic                  push,
  output srec_pkg::line_sum_t   push_data
);

  logic [srec_pkg::POS_W-1:0] char_position, char_position_next;
  srec_pkg::rec_type_t        record_type, record_type_next;
  logic [7:0]                 declared_byte_count, declared_byte_count_next;
  logic [7:0]                 running_byte_sum, running_byte_sum_next;
  logic [3:0]                 pending_high_nibble, pending_high_nibble_next;
  logic [7:0]                 delayed_digits, delayed_digits_next;
  logic                       format_ok, format_ok_next;
  logic [31:0]                field_value, field_value_next;

  logic [4:0] hex_v;
  logic [3:0] nib;
  logic [7:0] byte_val;
  logic       accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    hex_v = srec_pkg::hex_nibble(in_char);
    nib   = hex_v[4] ? 4'd0 : hex_v[3:0];
    byte_val = {pending_high_nibble, nib};

    char_position_next       = (char_position == srec_pkg::POSITION_LIMIT) ?
                               char_position : char_position + 1'b1;
    record_type_next         = record_type;
    declared_byte_count_next = declared_byte_count;
    running_byte_sum_next    = running_byte_sum;
    pending_high_nibble_next = pending_high_nibble;
    delayed_digits_next      = delayed_digits;
    format_ok_next           = format_ok;
    field_value_next         = field_value;

    if (char_position == '0) begin
      if (in_char != srec_pkg::CHAR_S) format_ok_next = 1'b0;
    end else begin
      if (hex_v[4]) format_ok_next = 1'b0;
      if (char_position == srec_pkg::POS_W'(1)) begin
        if (hex_v > srec_pkg::DEC_DIGIT_MAX || hex_v == srec_pkg::RESERVED_TYPE) begin
          format_ok_next = 1'b0;
        end
        record_type_next = srec_pkg::rec_type_t'(nib);
      end else begin
        if (!char_position[0]) begin
          pending_high_nibble_next = nib;
        end else begin
          running_byte_sum_next = running_byte_sum + byte_val;
          if (char_position == srec_pkg::POS_W'(3)) declared_byte_count_next = byte_val;
        end
        if (char_position >= srec_pkg::POS_W'(4)) begin
          if (char_position >= srec_pkg::POS_W'(6)) begin
            field_value_next = {field_value[27:0], delayed_digits[7:4]};
          end
          delayed_digits_next = {delayed_digits[3:0], nib};
        end
      end
    end
  end

  always_comb begin
    push                   = accept && in_last;
    push_data.format_ok    = format_ok_next;
    push_data.line_len     = {1'b0, char_position} + srec_pkg::LEN_W'(1);
    push_data.record_type  = record_type_next;
    push_data.decl_count   = declared_byte_count_next;
    push_data.byte_sum     = running_byte_sum_next;
    push_data.field_value  = field_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_last)) begin
      char_position       <= '0;
      record_type         <= srec_pkg::REC_S0;
      declared_byte_count <= '0;
      running_byte_sum    <= '0;
      pending_high_nibble <= '0;
      delayed_digits      <= '0;
      format_ok           <= 1'b1;
      field_value         <= '0;
    end else if (accept) begin
      char_position       <= char_position_next;
      record_type         <= record_type_next;
      declared_byte_count <= declared_byte_count_next;
      running_byte_sum    <= running_byte_sum_next;
      pending_high_nibble <= pending_high_nibble_next;
      delayed_digits      <= delayed_digits_next;
      format_ok           <= format_ok_next;
      field_value         <= field_value_next;
    end
  end

endmodule

FILE: rtl/srec_queue.sv
// ----------------------------------------------------------------------------
// srec_queue
// short fifo of line summaries between scanner and verdict stage
// ----------------------------------------------------------------------------
module srec_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  srec_pkg::line_sum_t push_data,
  input  logic                pop,
  output srec_pkg::line_sum_t pop_data,
  output srec_pkg::q_stat_t   stat
);

  srec_pkg::line_sum_t entries [srec_pkg::QUEUE_DEPTH];
  logic [srec_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [srec_pkg::QCNT_W-1:0] count;

  always_comb begin
    stat.count = count;
    stat.avail = (count != '0);
    stat.full  = (count == srec_pkg::QCNT_W'(srec_pkg::QUEUE_DEPTH));
    pop_data   = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/srec_back.sv
// ----------------------------------------------------------------------------
// srec_back
// verdict stage: length, checksum and record count checks, record counter,
// and the output register
// ----------------------------------------------------------------------------
module srec_back #(
  parameter int unsigned MAX_LINE_CHARS = srec_pkg::MAX_LINE_CHARS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_avail,
  input  srec_pkg::line_sum_t q_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                line_valid,
  output srec_pkg::err_kind_t error_kind,
  output logic [31:0]         data_records_seen
);

  logic [31:0]                   record_counter, record_counter_next;
  srec_pkg::err_kind_t           err;
  logic [srec_pkg::LEN_W-1:0]    min_len;
  logic [srec_pkg::LEN_W-1:0]    body_len;
  logic                          len_bad;
  logic                          is_data, is_count;

  assign pop = q_avail && (!out_valid || out_ready);

  always_comb begin
    min_len  = srec_pkg::FRAME_CHARS +
               srec_pkg::LEN_W'(srec_pkg::addr_chars(q_data.record_type));
    body_len = q_data.line_len - srec_pkg::HEADER_CHARS;
    len_bad  = (q_data.line_len < min_len) ||
               (q_data.line_len > srec_pkg::LEN_W'(MAX_LINE_CHARS)) ||
               ({2'b0, q_data.decl_count, 1'b0} != body_len);
    is_data  = (q_data.record_type == srec_pkg::REC_S1) ||
               (q_data.record_type == srec_pkg::REC_S2) ||
               (q_data.record_type == srec_pkg::REC_S3);
    is_count = (q_data.record_type == srec_pkg::REC_S5) ||
               (q_data.record_type == srec_pkg::REC_S6);
    record_counter_next = record_counter;
    priority if (!q_data.format_ok) begin
      err = srec_pkg::ERR_FORMAT;
    end else if (len_bad) begin
      err = srec_pkg::ERR_LENGTH;
    end else if (q_data.byte_sum != srec_pkg::SUM_GOOD) begin
      err = srec_pkg::ERR_CHECKSUM;
    end else if (is_count && (record_counter != q_data.field_value)) begin
      err = srec_pkg::ERR_COUNT;
    end else begin
      err = srec_pkg::ERR_NONE;
      if (is_data) record_counter_next = record_counter + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_counter <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        record_counter <= record_counter_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      line_valid        <= (err == srec_pkg::ERR_NONE);
      error_kind        <= err;
      data_records_seen <= record_counter_next;
    end
  end

endmodule

FILE: tb/srec_line_checker_core_tb.sv
// ----------------------------------------------------------------------------
// srec_line_checker_core_tb
// streams s-record lines into the checker one character per transfer and
// compares each verdict transfer against a line scanner kept in the bench.
// directed lines cover record types S0 to S9, SA and SF, each error kind,
// short lines and a count field wider than 32 bits; then random lines follow,
// mostly well formed with random content, the rest damaged or pure noise. both
// sides pause at random in stretches
// ----------------------------------------------------------------------------
module srec_line_checker_core_tb;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_xfer_t;

  typedef struct {
    logic                ok;
    srec_pkg::err_kind_t kind;
    logic [31:0]         count;
  } verdict_t;

  typedef enum int {
    FLAW_NONE, FLAW_SUM, FLAW_COUNT, FLAW_CHAR, FLAW_START, FLAW_CUT, FLAW_TYPE
  } flaw_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // line_char
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // line_valid, error_kind, data_records_seen, pad

  srec_line_checker_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  char_xfer_t pending_chars[$];
  verdict_t   expected_verdicts[$];
  logic [7:0] line_buf[$];
  logic [7:0] rec_bytes[$];

  int fail_count = 0;
  int chars_sent = 0;
  int verdicts_seen = 0;
  int valid_lines_seen = 0;
  int lines_made = 0;
  int planned_count = 0;
  int type_pool[12] = '{0, 1, 1, 2, 2, 3, 3, 5, 6, 7, 8, 9};

  // line scanner state
  logic [srec_pkg::POS_W-1:0] cur_pos;
  srec_pkg::rec_type_t        cur_type;
  logic [7:0]                 cur_count;
  logic [7:0]                 cur_sum;
  logic [3:0]                 cur_high_nib;
  logic [7:0]                 cur_lag;
  logic                       cur_fmt_ok;
  logic [31:0]                cur_field;
  logic [31:0]                data_rec_count;

  function automatic logic [4:0] char_to_nibble(input logic [7:0] c);
    if (c >= srec_pkg::CHAR_ZERO && c <= srec_pkg::CHAR_NINE) return {1'b0, c[3:0]};
    if (c >= srec_pkg::CHAR_A && c <= srec_pkg::CHAR_F) return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  function automatic int unsigned addr_field_chars(input srec_pkg::rec_type_t t);
    case (t)
      srec_pkg::REC_S2, srec_pkg::REC_S6, srec_pkg::REC_S8: return 6;
      srec_pkg::REC_S3, srec_pkg::REC_S7: return 8;
      default: return 4;
    endcase
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    return (n < 4'd10) ? srec_pkg::CHAR_ZERO + {4'd0, n}
                       : srec_pkg::CHAR_A + {4'd0, n - 4'd10};
  endfunction

  task automatic clear_line_state();
    cur_pos = '0;
    cur_type = srec_pkg::REC_S0;
    cur_count = '0;
    cur_sum = '0;
    cur_high_nib = '0;
    cur_lag = '0;
    cur_fmt_ok = 1'b1;
    cur_field = '0;
  endtask

  task automatic scan_line_char(input logic [7:0] c, input logic eol);
    logic [4:0] v;
    logic [3:0] nib;
    logic [7:0] b;
    int unsigned line_len;
    int unsigned min_len;
    srec_pkg::err_kind_t kind;
    verdict_t want;
    if (cur_pos == 0) begin
      if (c != srec_pkg::CHAR_S) cur_fmt_ok = 1'b0;
    end else begin
      v = char_to_nibble(c);
      nib = v[4] ? 4'd0 : v[3:0];
      if (v[4]) cur_fmt_ok = 1'b0;
      if (cur_pos == 1) begin
        if (v > srec_pkg::DEC_DIGIT_MAX || v == srec_pkg::RESERVED_TYPE) cur_fmt_ok = 1'b0;
        cur_type = srec_pkg::rec_type_t'(nib);
      end else begin
        if (!cur_pos[0]) begin
          cur_high_nib = nib;
        end else begin
          b = {cur_high_nib, nib};
          cur_sum = cur_sum + b;
          if (cur_pos == 3) cur_count = b;
        end
        if (cur_pos >= 4) begin
          if (cur_pos >= 6) cur_field = {cur_field[27:0], cur_lag[7:4]};
          cur_lag = {cur_lag[3:0], nib};
        end
      end
    end
    line_len = cur_pos + 1;
    if (cur_pos != srec_pkg::POSITION_LIMIT) cur_pos = cur_pos + 1'b1;
    if (eol) begin
      min_len = 6 + addr_field_chars(cur_type);
      kind = srec_pkg::ERR_NONE;
      if (!cur_fmt_ok) begin
        kind = srec_pkg::ERR_FORMAT;
      end else if (line_len < min_len || line_len > srec_pkg::MAX_LINE_CHARS_DEFAULT ||
                   2 * cur_count != line_len - 4) begin
        kind = srec_pkg::ERR_LENGTH;
      end else if (cur_sum != srec_pkg::SUM_GOOD) begin
        kind = srec_pkg::ERR_CHECKSUM;
      end else begin
        if (cur_type == srec_pkg::REC_S1 || cur_type == srec_pkg::REC_S2 ||
            cur_type == srec_pkg::REC_S3)
          data_rec_count = data_rec_count + 1;
        if ((cur_type == srec_pkg::REC_S5 || cur_type == srec_pkg::REC_S6) &&
            data_rec_count != cur_field)
          kind = srec_pkg::ERR_COUNT;
      end
      want.ok = (kind == srec_pkg::ERR_NONE);
      want.kind = kind;
      want.count = data_rec_count;
      expected_verdicts.push_back(want);
      clear_line_state();
    end
  endtask

  // stimulus helpers
  task automatic push_hex_byte(input logic [7:0] b);
    line_buf.push_back(nibble_char(b[7:4]));
    line_buf.push_back(nibble_char(b[3:0]));
  endtask

  task automatic emit_line();
    char_xfer_t x;
    foreach (line_buf[i]) begin
      x.ch = line_buf[i];
      x.last = (i == line_buf.size() - 1);
      pending_chars.push_back(x);
    end
    line_buf.delete();
    lines_made++;
  endtask

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [4:0] v;
    case ($urandom_range(0, 4))
      0: c = 8'h61 + 8'($urandom_range(0, 5));
      1: c = 8'h00;
      2: c = 8'hFF;
      3: c = srec_pkg::CHAR_F + 8'd1;
      default: begin
        v = 5'h00;
        while (!v[4]) begin
          c = 8'($urandom_range(0, 255));
          v = char_to_nibble(c);
        end
      end
    endcase
    return c;
  endfunction

  // record from rec_bytes (address and data), with an optional defect
  task automatic make_record(input int t, input flaw_t flaw);
    logic [7:0] cnt;
    logic [7:0] chk;
    logic [7:0] c;
    cnt = 8'(rec_bytes.size() + 1);
    if (flaw == FLAW_COUNT) cnt = $urandom_range(0, 1) ? cnt + 8'd1 : cnt - 8'd1;
    chk = cnt;
    foreach (rec_bytes[i]) chk = chk + rec_bytes[i];
    chk = ~chk;
    if (flaw == FLAW_SUM) chk = chk ^ 8'($urandom_range(1, 255));
    line_buf.delete();
    line_buf.push_back(srec_pkg::CHAR_S);
    line_buf.push_back(nibble_char(t[3:0]));
    push_hex_byte(cnt);
    foreach (rec_bytes[i]) push_hex_byte(rec_bytes[i]);
    push_hex_byte(chk);
    case (flaw)
      FLAW_CHAR: line_buf[$urandom_range(2, line_buf.size() - 1)] = non_hex_char();
      FLAW_START: begin
        c = srec_pkg::CHAR_S;
        while (c == srec_pkg::CHAR_S) c = 8'($urandom_range(0, 255));
        line_buf[0] = c;
      end
      FLAW_CUT: repeat ($urandom_range(1, 3)) void'(line_buf.pop_back());
      FLAW_TYPE: begin
        case ($urandom_range(0, 2))
          0: line_buf[1] = nibble_char(4'd4);
          1: line_buf[1] = srec_pkg::CHAR_A + 8'($urandom_range(0, 5));
          default: line_buf[1] = non_hex_char();
        endcase
      end
      default: ;
    endcase
    emit_line();
    if (flaw == FLAW_NONE && t >= 1 && t <= 3 &&
        rec_bytes.size() >= addr_field_chars(srec_pkg::rec_type_t'(t)) / 2)
      planned_count++;
  endtask

  task automatic load_count_field(input int nbytes, input logic [31:0] value);
    rec_bytes.delete();
    for (int i = nbytes - 1; i >= 0; i--) rec_bytes.push_back(value[8*i +: 8]);
  endtask

  task automatic load_random_bytes(input int n);
    rec_bytes.delete();
    repeat (n) rec_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic random_record();
    int t;
    int abytes;
    int r;
    flaw_t flaw;
    t = type_pool[$urandom_range(0, 11)];
    r = $urandom_range(0, 99);
    flaw = (r < 70) ? FLAW_NONE : flaw_t'($urandom_range(1, 6));
    abytes = addr_field_chars(srec_pkg::rec_type_t'(t)) / 2;
    if (t == 5 || t == 6) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        load_count_field(abytes, planned_count);
      end else if (r < 8) begin
        load_random_bytes($urandom_range(0, 4));
        for (int i = 3; i >= 0; i--) rec_bytes.push_back(planned_count[8*i +: 8]);
      end else begin
        load_random_bytes(abytes + $urandom_range(0, 3));
      end
    end else begin
      load_random_bytes(abytes + (($urandom_range(0, 99) < 90) ? $urandom_range(0, 8)
                                                                : $urandom_range(9, 40)));
    end
    make_record(t, flaw);
  endtask

  task automatic noise_line();
    int n;
    n = $urandom_range(1, 20);
    line_buf.delete();
    repeat (n) begin
      if ($urandom_range(0, 1)) line_buf.push_back(nibble_char(4'($urandom_range(0, 15))));
      else line_buf.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1)) line_buf[0] = srec_pkg::CHAR_S;
    emit_line();
  endtask

  // driver
  int tx_gap = 0;
  bit tx_gap_on = 1'b1;
  int tx_phase_left = 60;

  always @(posedge clk) begin : drive
    char_xfer_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        scan_line_char(s_tdata, s_tlast);
        chars_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          s_tvalid <= 1'b0;
          tx_gap--;
        end else if (pending_chars.size() != 0) begin
          nxt = pending_chars.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nxt.ch;
          s_tlast <= nxt.last;
          tx_gap = tx_gap_on ? $urandom_range(0, 5) : 0;
          tx_phase_left--;
          if (tx_phase_left == 0) begin
            tx_gap_on = !tx_gap_on;
            tx_phase_left = $urandom_range(20, 120);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int rx_stall = 0;
  bit rx_stall_on = 1'b1;
  int rx_phase_left = 8;

  always @(posedge clk) begin : watch
    verdict_t want;
    logic got_ok;
    srec_pkg::err_kind_t got_kind;
    logic [31:0] got_count;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_ok = m_tdata[0];
        got_kind = srec_pkg::err_kind_t'(m_tdata[3:1]);
        got_count = m_tdata[35:4];
        verdicts_seen++;
        if (got_ok) valid_lines_seen++;
        if (m_tdata[39:36] != 4'd0) begin
          $display("%0t: pad bits expected 0 actual %0h", $time, m_tdata[39:36]);
          fail_count++;
        end
        if (expected_verdicts.size() == 0) begin
          $display("%0t: verdict with none expected, actual valid %0d kind %0d count %0d",
                   $time, got_ok, got_kind, got_count);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (got_ok !== want.ok) begin
            $display("%0t: line_valid expected %0d actual %0d", $time, want.ok, got_ok);
            fail_count++;
          end
          if (got_kind !== want.kind) begin
            $display("%0t: error_kind expected %0d actual %0d", $time, want.kind, got_kind);
            fail_count++;
          end
          if (got_count !== want.count) begin
            $display("%0t: data_records_seen expected %0d actual %0d",
                     $time, want.count, got_count);
            fail_count++;
          end
        end
        rx_stall = rx_stall_on ? $urandom_range(0, 5) : 0;
        rx_phase_left--;
        if (rx_phase_left == 0) begin
          rx_stall_on = !rx_stall_on;
          rx_phase_left = $urandom_range(4, 20);
        end
      end
      if (rx_stall > 0) begin
        m_tready <= 1'b0;
        rx_stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    clear_line_state();
    data_rec_count = '0;

    // directed lines
    line_buf.push_back(srec_pkg::CHAR_S);
    emit_line();
    line_buf.push_back(8'h00);
    emit_line();
    line_buf.push_back(8'hFF);
    line_buf.push_back(srec_pkg::CHAR_S);
    emit_line();
    load_count_field(2, 0);
    make_record(0, FLAW_NONE);
    rec_bytes = '{8'h12, 8'h34, 8'h00, 8'hFF};
    make_record(1, FLAW_NONE);
    rec_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hAA};
    make_record(2, FLAW_NONE);
    load_random_bytes(4);
    make_record(3, FLAW_NONE);
    load_count_field(2, planned_count);
    make_record(5, FLAW_NONE);
    load_count_field(2, planned_count + 1);
    make_record(5, FLAW_NONE);
    load_count_field(3, planned_count);
    make_record(6, FLAW_NONE);
    // count field wider than 32 bits, low word matches
    rec_bytes = '{8'hDE, 8'hAD, 8'hBE, 8'hEF};
    for (int i = 3; i >= 0; i--) rec_bytes.push_back(planned_count[8*i +: 8]);
    make_record(5, FLAW_NONE);
    load_random_bytes(4);
    make_record(7, FLAW_NONE);
    load_random_bytes(3);
    make_record(8, FLAW_NONE);
    load_random_bytes(2);
    make_record(9, FLAW_NONE);
    load_random_bytes(2);
    make_record(4, FLAW_NONE);
    load_random_bytes(2);
    make_record(10, FLAW_NONE);
    load_random_bytes(2);
    make_record(15, FLAW_NONE);
    load_random_bytes(3);
    make_record(1, FLAW_CHAR);
    load_random_bytes(3);
    make_record(1, FLAW_SUM);
    load_random_bytes(2);
    make_record(9, FLAW_COUNT);
    load_random_bytes(4);
    make_record(3, FLAW_START);
    load_random_bytes(3);
    make_record(2, FLAW_CUT);
    // byte count agrees but shorter than the address needs
    rec_bytes = '{8'h00};
    make_record(1, FLAW_NONE);
    load_random_bytes(3);
    make_record(3, FLAW_NONE);

    // random lines
    while (pending_chars.size() < 640) begin
      if ($urandom_range(0, 9) == 0) noise_line();
      else random_record();
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() != 0 || s_tvalid) @(negedge clk);
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (expected_verdicts.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, expected_verdicts.size());
      fail_count++;
    end

    $display("sent %0d characters in %0d lines", chars_sent, lines_made);
    $display("checked %0d verdicts, %0d lines valid, final data record count %0d",
             verdicts_seen, valid_lines_seen, data_rec_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #500_000;
    $display("%0t: timeout", $time);
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: files.f
rtl/srec_pkg.sv
rtl/srec_front.sv
rtl/srec_queue.sv
rtl/srec_back.sv
rtl/srec_line_checker_core.sv
tb/srec_line_checker_core_tb.sv
